FILE: hw/rtl/deq_pkg.sv
// Shared widths, operation codes and cell control type for the deque.
package deq_pkg;

	localparam int DATA_W      = 32;
	localparam int MODE_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_DEF   = 32;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
	localparam logic [OP_W-1:0] OP_ROTATE     = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] push_data;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/deq_cell.sv
// One storage cell of the deque chain, shifting towards either neighbour.
module deq_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_pkg::cell_ctrl_t        ctrl,
	input  logic [deq_pkg::DATA_W-1:0] left_data,
	input  logic                       left_valid,
	input  logic [deq_pkg::DATA_W-1:0] right_data,
	input  logic                       right_valid,
	input  logic [deq_pkg::DATA_W-1:0] head_data,
	output logic [deq_pkg::DATA_W-1:0] data,
	output logic                       valid,
	output logic                       is_back
);

	logic [deq_pkg::DATA_W-1:0] data_q;
	logic                       valid_q;
	logic [deq_pkg::DATA_W-1:0] data_nxt;
	logic                       valid_nxt;

	always_comb begin
		data_nxt  = data_q;
		valid_nxt = valid_q;
		unique case (ctrl.op)
			deq_pkg::OP_PUSH_FRONT: begin
				data_nxt  = left_data;
				valid_nxt = left_valid;
			end
			deq_pkg::OP_PUSH_BACK: begin
				if (!valid_q && left_valid) begin
					data_nxt  = ctrl.push_data;
					valid_nxt = 1'b1;
				end
			end
			deq_pkg::OP_POP_FRONT: begin
				data_nxt  = right_data;
				valid_nxt = right_valid;
			end
			deq_pkg::OP_POP_BACK: begin
				if (valid_q && !right_valid) begin
					valid_nxt = 1'b0;
				end
			end
			deq_pkg::OP_ROTATE: begin
				if (right_valid) begin
					data_nxt = right_data;
				end else if (valid_q) begin
					data_nxt = head_data;
				end
			end
			default: begin
				data_nxt  = data_q;
				valid_nxt = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data    = data_q;
	assign valid   = valid_q;
	assign is_back = valid_q && !right_valid;

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue built from a chain of cells.
//
// Input channel s_*: s_tuser carries the operation (push front, push back,
// pop front, pop back, dump), s_tdata the value to push. Output channel m_*:
// m_tdata carries the result value, m_tuser the status (ok, empty, full),
// m_tlast marks the final result of one input transaction.
// Entries sit packed in the cells from the front; a push or pop at the front
// shifts every cell towards a neighbour and one at the back writes or clears
// a single cell, so a push or pop finishes in the cycle it is accepted and
// its result is in the output register in the next cycle. A new transaction
// is taken each cycle the register is free or being drained and no dump runs.
// A dump rotates the chain once per result, so a dump of N entries gives N
// results and blocks input until the last result is in the output register;
// the rotation leaves the contents in their original order.
// Reset empties the deque and the output register at once; no clearing
// pass is needed. When the receiver stalls, the output register holds its
// result and input stalls with it.
// Unused operation codes are accepted and produce no result.
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [deq_pkg::DATA_W-1:0]   s_tdata,  // [31:0] value
	input  logic [deq_pkg::MODE_W-1:0]   s_tuser,  // [2:0] mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [deq_pkg::DATA_W-1:0]   m_tdata,  // [31:0] value_res
	output logic [deq_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
	output logic                         m_tlast
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic                         state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             dump_left_q;
	logic                         out_valid_q;
	logic [deq_pkg::DATA_W-1:0]   out_data_q;
	logic [deq_pkg::STATUS_W-1:0] out_status_q;
	logic                         out_last_q;

	logic [deq_pkg::DATA_W-1:0]   cell_data [DEPTH];
	logic [DEPTH-1:0]             cell_valid;
	logic [DEPTH-1:0]             cell_back;
	logic [deq_pkg::DATA_W-1:0]   back_data;
	deq_pkg::cell_ctrl_t          ctrl;

	logic                         out_free;
	logic                         in_fire;
	logic                         is_full;
	logic                         is_empty;

	logic                         load_out;
	logic [deq_pkg::DATA_W-1:0]   res_data;
	logic [deq_pkg::STATUS_W-1:0] res_status;
	logic                         res_last;
	logic                         state_nxt;
	logic [CNT_W-1:0]             count_nxt;
	logic [CNT_W-1:0]             dump_left_nxt;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = s_tvalid && s_tready;
	assign is_full  = cell_valid[DEPTH-1];
	assign is_empty = !cell_valid[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [deq_pkg::DATA_W-1:0] l_data;
		logic                       l_valid;
		logic [deq_pkg::DATA_W-1:0] r_data;
		logic                       r_valid;

		if (i == 0) begin : g_first
			assign l_data  = s_tdata;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.head_data   (cell_data[0]),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.is_back     (cell_back[i])
		);
	end

	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_data = back_data | (cell_data[i] & {deq_pkg::DATA_W{cell_back[i]}});
		end
	end

	always_comb begin
		ctrl.op        = deq_pkg::OP_HOLD;
		ctrl.push_data = s_tdata;
		load_out       = 1'b0;
		res_data       = '0;
		res_status     = deq_pkg::STATUS_OK;
		res_last       = 1'b1;
		state_nxt      = state_q;
		count_nxt      = count_q;
		dump_left_nxt  = dump_left_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					priority if (s_tuser == deq_pkg::MODE_PUSH_FRONT ||
						s_tuser == deq_pkg::MODE_PUSH_BACK) begin
						load_out = 1'b1;
						if (is_full) begin
							res_status = deq_pkg::STATUS_FULL;
						end else begin
							res_data  = s_tdata;
							count_nxt = count_q + 1'b1;
							ctrl.op   = (s_tuser == deq_pkg::MODE_PUSH_FRONT) ?
								deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
						end
					end else if (s_tuser == deq_pkg::MODE_POP_FRONT ||
						s_tuser == deq_pkg::MODE_POP_BACK) begin
						load_out = 1'b1;
						if (is_empty) begin
							res_status = deq_pkg::STATUS_EMPTY;
						end else begin
							count_nxt = count_q - 1'b1;
							if (s_tuser == deq_pkg::MODE_POP_FRONT) begin
								res_data = cell_data[0];
								ctrl.op  = deq_pkg::OP_POP_FRONT;
							end else begin
								res_data = back_data;
								ctrl.op  = deq_pkg::OP_POP_BACK;
							end
						end
					end else if (s_tuser == deq_pkg::MODE_DUMP) begin
						load_out = 1'b1;
						if (is_empty) begin
							res_status = deq_pkg::STATUS_EMPTY;
						end else begin
							res_data      = cell_data[0];
							ctrl.op       = deq_pkg::OP_ROTATE;
							res_last      = (count_q == CNT_W'(1));
							dump_left_nxt = count_q - 1'b1;
							if (count_q != CNT_W'(1)) begin
								state_nxt = ST_DUMP;
							end
						end
					end else begin
						load_out = 1'b0;
					end
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					load_out      = 1'b1;
					res_data      = cell_data[0];
					ctrl.op       = deq_pkg::OP_ROTATE;
					res_last      = (dump_left_q == CNT_W'(1));
					dump_left_nxt = dump_left_q - 1'b1;
					if (dump_left_q == CNT_W'(1)) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dump_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			count_q     <= count_nxt;
			dump_left_q <= dump_left_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + 1'b1)) == '0)
		else $error("occupied cells are not packed from the front");

	a_no_input_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> !s_tready)
		else $error("input taken during dump");

	a_dump_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP && state_nxt == ST_IDLE) |=> (m_tvalid && m_tlast))
		else $error("dump finished without a last result");

endmodule
